// ----- hw/rtl/cbbt_pkg.sv -----
// Shared types, field widths and codes of the circuit breaker backoff table.
`default_nettype none

package cbbt_pkg;

   // Default sizes of the entry table.
   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_KEY_BITS    = 32;

   // Field widths.
   localparam int MODE_W    = 2;
   localparam int KEY_IN_W  = 32;
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 16;
   localparam int THRESH_W  = 16;
   localparam int INIT_W    = 16;
   localparam int BACKOFF_W = 31;
   localparam int DELAY_W   = 32;
   localparam int AGENTS_W  = 5;

   // Port widths.
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REQ_TUSER_W   = MODE_W;
   localparam int REQ_TDATA_W   = KEY_IN_W + TIME_W;
   localparam int RSP_FIELDS_W  = 1 + BACKOFF_W + 1 + 1 + COUNT_W;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_FIELDS_W;

   // Register values after reset.
   localparam logic [THRESH_W-1:0]  RST_THRESHOLD = 16'd3;
   localparam logic [INIT_W-1:0]    RST_INIT      = 16'd100;
   localparam logic [BACKOFF_W-1:0] RST_CAP       = 31'd30000;
   localparam logic [DELAY_W-1:0]   RST_DELAY     = 32'd60;
   localparam logic [AGENTS_W-1:0]  RST_AGENTS    = 5'd16;

   // Operation carried in the request tuser; code three is lookup only.
   typedef enum logic [MODE_W-1:0] {
      MODE_FAILURE = 2'd0,
      MODE_SUCCESS = 2'd1,
      MODE_QUERY   = 2'd2
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD    = 3'd0,
      CSR_INIT_BACKOFF = 3'd1,
      CSR_BACKOFF_CAP  = 3'd2,
      CSR_REOPEN_DELAY = 3'd3,
      CSR_AGENTS       = 3'd4
   } csr_index_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic take_hit;
      logic take_miss;
      logic update;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic scan_end;
      logic rsp_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/cbbt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cbbt_ctrl.sv -----
// Controller state machine: request intake, table scan, update and result.
`default_nettype none

module cbbt_ctrl
   import cbbt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_UPDATE;
            end else if (sts.scan_end) begin
               cmd.take_miss = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cbbt_datapath.sv -----
// Datapath: configuration registers, entry RAM scan, entry update and result register.
`default_nettype none

module cbbt_datapath
   import cbbt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire dp_cmd_type             cmd,
   output dp_sts_type                  sts,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW       = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW     = (CW > AGENTS_W) ? CW : AGENTS_W;
   localparam int FAIL_LO  = KEY_BITS;
   localparam int OPEN_BIT = KEY_BITS + COUNT_W;
   localparam int TIME_LO  = OPEN_BIT + 1;
   localparam int EW       = TIME_LO + TIME_W;
   localparam int SHIFT_W  = INIT_W + 32;

   // Configuration registers.
   logic [THRESH_W-1:0]  thresh_ff;
   logic [INIT_W-1:0]    init_ff;
   logic [BACKOFF_W-1:0] cap_ff;
   logic [DELAY_W-1:0]   delay_ff;
   logic [AGENTS_W-1:0]  agents_ff;

   // Request held for the duration of one item.
   mode_type             mode_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [TIME_W-1:0]    now_ff;

   // Scan control.
   logic [CW-1:0] scan_ff, scan_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff;
   logic [CW-1:0] used_ff, used_in;
   logic          rd_issue;
   logic          room;

   // Working copy of the selected entry.
   logic [KEY_BITS-1:0] ent_key_ff;
   logic [COUNT_W-1:0]  ent_fail_ff;
   logic                ent_open_ff;
   logic [TIME_W-1:0]   ent_time_ff;
   logic [AW-1:0]       ent_idx_ff;
   logic                tracked_ff;
   logic                avail_ff;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // Entry RAM ports.
   logic          ram_wr_en;
   logic [EW-1:0] ram_wr_data;
   logic [EW-1:0] ram_rd_data;

   // Update results.
   logic [COUNT_W-1:0] fail_inc;
   logic [TIME_W-1:0]  elapsed;
   logic [COUNT_W-1:0] new_fail;
   logic               new_open;
   logic [TIME_W-1:0]  new_time;
   logic               new_avail;

   // Backoff.
   logic [COUNT_W-1:0]   shift_amt;
   logic                 big_shift;
   logic [SHIFT_W-1:0]   shifted;
   logic [BACKOFF_W-1:0] backoff;
   logic [RSP_TDATA_W-1:0] rsp_word;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= RST_THRESHOLD;
         init_ff   <= RST_INIT;
         cap_ff    <= RST_CAP;
         delay_ff  <= RST_DELAY;
         agents_ff <= RST_AGENTS;
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD:    thresh_ff <= csr_data[THRESH_W-1:0];
            CSR_INIT_BACKOFF: init_ff   <= csr_data[INIT_W-1:0];
            CSR_BACKOFF_CAP:  cap_ff    <= csr_data[BACKOFF_W-1:0];
            CSR_REOPEN_DELAY: delay_ff  <= csr_data[DELAY_W-1:0];
            CSR_AGENTS:       agents_ff <= csr_data[AGENTS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the request on its transfer.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= mode_type'(req_tuser[MODE_W-1:0]);
         key_ff  <= KEY_BITS'(req_tdata[KEY_IN_W-1:0]);
         now_ff  <= req_tdata[KEY_IN_W +: TIME_W];
      end
   end

   // One RAM read per scan cycle, entries zero to one below the fill count.
   assign rd_issue = cmd.scan_step && (scan_ff != used_ff);

   // Room to append: below the table size and below the allocation limit (no limit when zero).
   assign room = (used_ff != CW'(TABLE_DEPTH)) &&
                 ((agents_ff == '0) || (CMPW'(used_ff) < CMPW'(agents_ff)));

   assign sts.hit      = rd_pend_ff && (ram_rd_data[KEY_BITS-1:0] == key_ff);
   assign sts.scan_end = !rd_pend_ff && (scan_ff == used_ff);
   assign sts.rsp_free = !rsp_valid_ff;

   // Next values of the scan control and fill count.
   always_comb begin
      scan_in    = scan_ff;
      rd_pend_in = rd_pend_ff;
      used_in    = used_ff;
      if (cmd.load_req) begin
         scan_in    = '0;
         rd_pend_in = 1'b0;
      end else if (cmd.scan_step) begin
         rd_pend_in = rd_issue;
         if (rd_issue) begin
            scan_in = scan_ff + 1'b1;
         end
      end
      if (cmd.take_miss && room) begin
         used_in = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         rd_pend_ff <= 1'b0;
         used_ff    <= '0;
      end else begin
         scan_ff    <= scan_in;
         rd_pend_ff <= rd_pend_in;
         used_ff    <= used_in;
      end
   end

   // Remember which entry the pending read returns.
   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         rd_idx_ff <= scan_ff[AW-1:0];
      end
   end

   // Entry state after this item's operation.
   always_comb begin
      fail_inc  = (ent_fail_ff == '1) ? ent_fail_ff : ent_fail_ff + 1'b1;
      elapsed   = now_ff - ent_time_ff;
      new_fail  = ent_fail_ff;
      new_open  = ent_open_ff;
      new_time  = ent_time_ff;
      new_avail = !ent_open_ff;
      case (mode_ff)
         MODE_FAILURE: begin
            new_fail = fail_inc;
            if ((fail_inc >= thresh_ff) && !ent_open_ff) begin
               new_open = 1'b1;
               new_time = now_ff;
            end
            new_avail = !new_open;
         end
         MODE_SUCCESS: begin
            new_fail  = '0;
            new_open  = 1'b0;
            new_avail = 1'b1;
         end
         MODE_QUERY: begin
            if (!ent_open_ff) begin
               new_avail = 1'b1;
            end else if (elapsed >= delay_ff) begin
               new_open  = 1'b0;
               new_avail = 1'b1;
            end else begin
               new_avail = 1'b0;
            end
         end
         default: begin
            // Lookup only: the entry stays as it is.
            new_avail = !ent_open_ff;
         end
      endcase
   end

   // Working entry: loaded from the RAM on a hit, fresh on a miss,
   // then replaced by the updated values.
   always_ff @(posedge clock) begin
      if (cmd.take_hit) begin
         ent_key_ff  <= ram_rd_data[KEY_BITS-1:0];
         ent_fail_ff <= ram_rd_data[FAIL_LO +: COUNT_W];
         ent_open_ff <= ram_rd_data[OPEN_BIT];
         ent_time_ff <= ram_rd_data[TIME_LO +: TIME_W];
         ent_idx_ff  <= rd_idx_ff;
         tracked_ff  <= 1'b1;
      end else if (cmd.take_miss) begin
         ent_key_ff  <= key_ff;
         ent_fail_ff <= '0;
         ent_open_ff <= 1'b0;
         ent_time_ff <= '0;
         ent_idx_ff  <= used_ff[AW-1:0];
         tracked_ff  <= room;
      end else if (cmd.update) begin
         ent_fail_ff <= new_fail;
         ent_open_ff <= new_open;
         ent_time_ff <= new_time;
         avail_ff    <= new_avail;
      end
   end

   // Write the updated entry back, key included for a fresh one.
   assign ram_wr_en   = cmd.update && tracked_ff;
   assign ram_wr_data = {new_time, new_open, new_fail, ent_key_ff};

   cbbt_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ent_idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (rd_issue),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Backoff is zero for a zero count or initial value, else the initial value shifted by count minus one, capped.
   assign shift_amt = ent_fail_ff - 1'b1;
   assign big_shift = |shift_amt[COUNT_W-1:5];
   assign shifted   = SHIFT_W'(init_ff) << shift_amt[4:0];

   always_comb begin
      if ((ent_fail_ff == '0) || (init_ff == '0)) begin
         backoff = '0;
      end else if (big_shift || (shifted > SHIFT_W'(cap_ff))) begin
         backoff = cap_ff;
      end else begin
         backoff = shifted[BACKOFF_W-1:0];
      end
   end

   // Result word; an untracked key reports a closed, clean circuit.
   always_comb begin
      if (tracked_ff) begin
         rsp_word = {{RSP_PAD_W{1'b0}}, ent_fail_ff, ent_open_ff, avail_ff, backoff, 1'b1};
      end else begin
         rsp_word = {{RSP_PAD_W{1'b0}}, {COUNT_W{1'b0}}, 1'b0, 1'b1, {BACKOFF_W{1'b0}}, 1'b0};
      end
   end

   // Result register; it holds until the result transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(TABLE_DEPTH))
      else $error("fill count beyond table size");

   // The fill count only ever grows by one entry at a time.
   assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |-> (used_ff == $past(used_ff) + 1'b1))
      else $error("fill count moved by more than one");

   // A hit always comes from an entry below the fill count.
   assert property (@(posedge clock) disable iff (reset)
      sts.hit |-> (CW'(rd_idx_ff) < used_ff))
      else $error("hit on an unused entry");

   // A new result is never loaded over one that waits for transfer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid_ff)
      else $error("result overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/circuit_breaker_backoff_table_top.sv -----
// Top level of the circuit breaker table with exponential backoff.
// Each request looks its key up in a table of TABLE_DEPTH entries held in a RAM, appending
// the key when it is new and the table size and allocation limit allow, then records a
// failure, records a success, answers a query or only looks up, and returns one result.
// Keys are searched one RAM read per cycle; the sequential scan over the single RAM read
// port sets how long an item takes, and an item is held longer while the previous result
// waits for its transfer. One item is worked on at a time, and the result register lets
// the next request in while a result still waits for its transfer. Configuration must be
// written through the csr port only while idle; the block itself does not enforce this.
`default_nettype none

module circuit_breaker_backoff_table_top
   import cbbt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration write channel.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   // Request channel.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // req_tdata: agent_key [31:0], now_secs [63:32]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: mode [1:0]
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   // Result channel.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // rsp_tdata: tracked [0], backoff_ms [31:1], available [32], circuit_is_open [33],
   //            failure_count [49:34], zeros [55:50]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   cbbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cbbt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
